/* rtl/pmc_pkg.sv */
package pmc_pkg;

  localparam int DEV_COUNT = 16;
  localparam int DEV_W     = (DEV_COUNT > 1) ? $clog2(DEV_COUNT) : 1;
  localparam int IDX_W     = 4;
  localparam int MOT_W     = 16;
  localparam int SUM_W     = 32;
  localparam int TS_W      = 32;
  localparam int ANG_W     = 16;
  localparam int GRADE_W   = 4;

  // CORDIC datapath: sums scaled by 2^16 plus growth headroom
  localparam int CW           = 51;
  localparam int ZW           = 21;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam logic signed [ZW-1:0] ANGLE_PI = 21'sd205887;

  localparam int RND_W = 18;  // rounded angle before truncation to Q3.12

  typedef enum logic [1:0] {
    CMD_MOTION,
    CMD_CLEAR,
    CMD_PAUSE,
    CMD_COMPARE
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOTION,
    S_RD_SRC,
    S_RD_TGT,
    S_MULX,
    S_MULY,
    S_ADD,
    S_SQRT,
    S_DIV,
    S_ANGT_GO,
    S_ANGT_WAIT,
    S_ANGS_GO,
    S_ANGS_WAIT,
    S_ROUND,
    S_DONE
  } state_t;

  // atan(2^-i) in units of 2^-16 rad
  function automatic logic signed [ZW-1:0] atan_unit(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      4'd0:    r = 21'sd51472;
      4'd1:    r = 21'sd30386;
      4'd2:    r = 21'sd16055;
      4'd3:    r = 21'sd8150;
      4'd4:    r = 21'sd4091;
      4'd5:    r = 21'sd2047;
      4'd6:    r = 21'sd1024;
      4'd7:    r = 21'sd512;
      4'd8:    r = 21'sd256;
      4'd9:    r = 21'sd128;
      4'd10:   r = 21'sd64;
      4'd11:   r = 21'sd32;
      4'd12:   r = 21'sd16;
      4'd13:   r = 21'sd8;
      4'd14:   r = 21'sd4;
      default: r = 21'sd2;
    endcase
    return r;
  endfunction

  function automatic logic [GRADE_W-1:0] grade_of(input logic [RND_W-1:0] a);
    logic [GRADE_W-1:0] g;
    priority if (a == '0)          g = 4'd0;
    else if (a < RND_W'(41))       g = 4'd1;
    else if (a < RND_W'(205))      g = 4'd2;
    else if (a < RND_W'(410))      g = 4'd3;
    else if (a < RND_W'(615))      g = 4'd4;
    else if (a < RND_W'(820))      g = 4'd5;
    else if (a < RND_W'(1229))     g = 4'd6;
    else if (a < RND_W'(2048))     g = 4'd7;
    else                           g = 4'd8;
    return g;
  endfunction

endpackage

/* rtl/pmc_cordic.sv */
module pmc_cordic import pmc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] ynum,
  input  logic signed [SUM_W-1:0] xden,
  output logic                    done,
  output logic signed [ZW-1:0]    z
);

  logic                 busy;
  logic [STEP_W-1:0]    i;
  logic signed [CW-1:0] x, y;
  logic signed [CW-1:0] xs0, ys0, xsh, ysh;
  logic                 zero_vec;

  assign xs0      = CW'(xden) <<< 16;
  assign ys0      = CW'(ynum) <<< 16;
  assign zero_vec = (xden == '0) && (ynum == '0);
  assign xsh      = x >>> i;
  assign ysh      = y >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (busy && i == STEP_W'(CORDIC_STEPS - 1)) || (start && zero_vec);
      if (start) begin
        busy <= !zero_vec;
      end else if (busy && i == STEP_W'(CORDIC_STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      i <= '0;
      if (zero_vec) begin
        z <= '0;
      end else if (xs0 < 0) begin
        // left half plane: rotate by pi first
        z <= (ys0 >= 0) ? ANGLE_PI : -ANGLE_PI;
        x <= -xs0;
        y <= -ys0;
      end else begin
        z <= '0;
        x <= xs0;
        y <= ys0;
      end
    end else if (busy) begin
      i <= i + 1'b1;
      if (y > 0) begin
        x <= x + ysh;
        y <= y - xsh;
        z <= z + atan_unit(i);
      end else begin
        x <= x - ysh;
        y <= y + xsh;
        z <= z - atan_unit(i);
      end
    end
  end

endmodule

/* rtl/pointer_motion_comparator_unit.sv */
// Pointer motion comparator.
// Input channel (in_valid/in_stall) carries one command per transfer: a
// motion report, clear all sums, toggle pause, or compare two devices.
// Only a compare produces a result on the output channel (out_valid/out_stall).
// A transfer is taken when valid is high and stall is low.
// Clear and pause never raise in_stall; a motion report passes through the
// S_MOTION state. Before out_valid a compare runs two table reads, per device
// a squaring pass on the one shared multiplier and a 32-step bit-serial square
// root, a 48-step restoring divide, and two CORDIC vectoring passes on one
// shared CORDIC unit (a zero vector skips the rotation steps).
// in_stall stays high while an item is in progress.
// The result sits in an output register; the block takes new items while it
// waits. A second compare that finishes while the receiver still stalls
// holds in its last state until the output register frees up.
// Synchronous reset clears sums, seen flags, shortest intervals (to all ones)
// and the pause flag; the block is ready on the first cycle after reset.
module pointer_motion_comparator_unit import pmc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              command,
  input  logic [IDX_W-1:0]        device_index,
  input  logic [IDX_W-1:0]        other_index,
  input  logic signed [MOT_W-1:0] motion_dx,
  input  logic signed [MOT_W-1:0] motion_dy,
  input  logic [TS_W-1:0]         timestamp,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SUM_W-1:0] sum_x,
  output logic signed [SUM_W-1:0] sum_y,
  output logic [TS_W-1:0]         shortest_interval,
  output logic [31:0]             gain_ratio,
  output logic signed [ANG_W-1:0] angle_offset,
  output logic [GRADE_W-1:0]      grade,
  output logic                    comparable
);

  state_t state, state_next;

  logic signed [SUM_W-1:0] sum_x_tab [DEV_COUNT];
  logic signed [SUM_W-1:0] sum_y_tab [DEV_COUNT];
  logic [DEV_COUNT-1:0]    seen_tab;
  logic [TS_W-1:0]         last_tab  [DEV_COUNT];
  logic [TS_W-1:0]         short_tab [DEV_COUNT];
  logic                    paused;

  logic                    in_xfer;
  cmd_t                    cmd_in;
  logic [IDX_W-1:0]        dev_q, oth_q;
  logic signed [MOT_W-1:0] dx_q, dy_q;
  logic [TS_W-1:0]         ts_q;

  logic [IDX_W-1:0]        ridx;
  logic [DEV_W-1:0]        tidx;
  logic                    rd_ok;
  logic signed [SUM_W-1:0] rsx, rsy;
  logic [TS_W-1:0]         rshort, rlast;
  logic                    rseen;
  logic signed [SUM_W:0]   wx, wy;
  logic signed [SUM_W-1:0] satx, saty;
  logic [TS_W-1:0]         dt;
  logic                    upd_en;

  logic signed [SUM_W-1:0] fx, fy, tx, ty;
  logic [TS_W-1:0]         fshort;
  logic                    vsel;
  logic signed [SUM_W-1:0] mx, my;
  logic [SUM_W-1:0]        ax, ay;
  logic [63:0]             prod, acc, rad;
  logic [34:0]             srem, srem_sh, strial;
  logic [31:0]             sres;
  logic                    sge;
  logic [31:0]             fmag, tmag;
  logic [5:0]              cnt;
  logic [47:0]             dq;
  logic [32:0]             drem, drem_sh;
  logic                    dge;

  logic                    cstart, cdone;
  logic signed [SUM_W-1:0] cyn, cxd;
  logic signed [ZW-1:0]    cz, zt;
  logic signed [ZW:0]      zd;
  logic signed [ZW:0]      zrnd;
  logic signed [RND_W-1:0] ang;
  logic [RND_W-1:0]        aang;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cmd_in   = cmd_t'(command);

  // single table read port; address comes from the latched item
  assign ridx   = (state == S_RD_TGT) ? oth_q : dev_q;
  assign tidx   = DEV_W'(ridx);
  assign rd_ok  = int'(ridx) < DEV_COUNT;
  assign rsx    = rd_ok ? sum_x_tab[tidx] : '0;
  assign rsy    = rd_ok ? sum_y_tab[tidx] : '0;
  assign rshort = rd_ok ? short_tab[tidx] : '1;
  assign rlast  = last_tab[tidx];
  assign rseen  = rd_ok && seen_tab[tidx];

  assign wx   = (SUM_W+1)'(rsx) + (SUM_W+1)'(dx_q);
  assign wy   = (SUM_W+1)'(rsy) + (SUM_W+1)'(dy_q);
  assign satx = (wx[SUM_W] != wx[SUM_W-1]) ? {wx[SUM_W], {(SUM_W-1){!wx[SUM_W]}}}
                                           : wx[SUM_W-1:0];
  assign saty = (wy[SUM_W] != wy[SUM_W-1]) ? {wy[SUM_W], {(SUM_W-1){!wy[SUM_W]}}}
                                           : wy[SUM_W-1:0];
  assign dt     = ts_q - rlast;
  assign upd_en = (state == S_MOTION) && !paused && rd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEV_COUNT; k++) begin
        sum_x_tab[k] <= '0;
        sum_y_tab[k] <= '0;
        short_tab[k] <= '1;
      end
      seen_tab <= '0;
      paused   <= 1'b0;
    end else begin
      if (in_xfer && cmd_in == CMD_PAUSE) begin
        paused <= !paused;
      end
      if (in_xfer && cmd_in == CMD_CLEAR) begin
        for (int k = 0; k < DEV_COUNT; k++) begin
          sum_x_tab[k] <= '0;
          sum_y_tab[k] <= '0;
        end
      end else if (upd_en) begin
        sum_x_tab[tidx] <= satx;
        sum_y_tab[tidx] <= saty;
        seen_tab[tidx]  <= 1'b1;
        if (!rseen) begin
          short_tab[tidx] <= '1;
        end else if (dt != '0 && dt < rshort) begin
          short_tab[tidx] <= dt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      last_tab[tidx] <= ts_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (cmd_in)
            CMD_MOTION:  state_next = S_MOTION;
            CMD_COMPARE: state_next = S_RD_SRC;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_MOTION:    state_next = S_IDLE;
      S_RD_SRC:    state_next = S_RD_TGT;
      S_RD_TGT:    state_next = S_MULX;
      S_MULX:      state_next = S_MULY;
      S_MULY:      state_next = S_ADD;
      S_ADD:       state_next = S_SQRT;
      S_SQRT: begin
        if (cnt == 6'd31) state_next = vsel ? S_DIV : S_MULX;
      end
      S_DIV: begin
        if (cnt == 6'd47) state_next = S_ANGT_GO;
      end
      S_ANGT_GO:   state_next = S_ANGT_WAIT;
      S_ANGT_WAIT: begin
        if (cdone) state_next = S_ANGS_GO;
      end
      S_ANGS_GO:   state_next = S_ANGS_WAIT;
      S_ANGS_WAIT: begin
        if (cdone) state_next = S_ROUND;
      end
      S_ROUND:     state_next = S_DONE;
      S_DONE: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // magnitude: shared multiplier, then bit-serial square root
  assign mx = vsel ? tx : fx;
  assign my = vsel ? ty : fy;
  assign ax = mx[SUM_W-1] ? SUM_W'(-mx) : SUM_W'(mx);
  assign ay = my[SUM_W-1] ? SUM_W'(-my) : SUM_W'(my);

  assign srem_sh = {srem[32:0], rad[63:62]};
  assign strial  = {1'b0, sres, 2'b01};
  assign sge     = srem_sh >= strial;

  assign drem_sh = {drem[31:0], dq[47]};
  assign dge     = drem_sh >= {1'b0, tmag};

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      dev_q <= device_index;
      oth_q <= other_index;
      dx_q  <= motion_dx;
      dy_q  <= motion_dy;
      ts_q  <= timestamp;
    end
    unique case (state)
      S_RD_SRC: begin
        fx     <= rsx;
        fy     <= rsy;
        fshort <= rshort;
        vsel   <= 1'b0;
      end
      S_RD_TGT: begin
        tx <= rsx;
        ty <= rsy;
      end
      S_MULX: prod <= ax * ax;
      S_MULY: begin
        acc  <= prod;
        prod <= ay * ay;
      end
      S_ADD: begin
        rad  <= acc + prod;
        srem <= '0;
        sres <= '0;
        cnt  <= '0;
      end
      S_SQRT: begin
        srem <= sge ? srem_sh - strial : srem_sh;
        sres <= {sres[30:0], sge};
        rad  <= rad << 2;
        cnt  <= (cnt == 6'd31) ? '0 : cnt + 1'b1;
        if (cnt == 6'd31) begin
          if (vsel) begin
            tmag <= {sres[30:0], sge};
            dq   <= {fmag, 16'b0};
            drem <= '0;
          end else begin
            fmag <= {sres[30:0], sge};
            vsel <= 1'b1;
          end
        end
      end
      S_DIV: begin
        drem <= dge ? drem_sh - {1'b0, tmag} : drem_sh;
        dq   <= {dq[46:0], dge};
        cnt  <= cnt + 1'b1;
      end
      S_ANGT_WAIT: begin
        if (cdone) zt <= cz;
      end
      S_ANGS_WAIT: begin
        if (cdone) zd <= (ZW+1)'(zt) - (ZW+1)'(cz);
      end
      S_ROUND: ang <= zrnd[RND_W-1:0];
      default: ;
    endcase
  end

  assign zrnd = (zd + (ZW+1)'(8)) >>> 4;
  assign aang = ang[RND_W-1] ? RND_W'(-ang) : RND_W'(ang);

  assign cstart = (state == S_ANGT_GO) || (state == S_ANGS_GO);
  assign cyn    = (state == S_ANGT_GO) ? tx : fx;
  assign cxd    = (state == S_ANGT_GO) ? ty : fy;

  pmc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .ynum  (cyn),
    .xden  (cxd),
    .done  (cdone),
    .z     (cz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      sum_x             <= fx;
      sum_y             <= fy;
      shortest_interval <= fshort;
      gain_ratio        <= (tmag == '0) ? '0 :
                           (|dq[47:32]) ? '1 : dq[31:0];
      angle_offset      <= ang[ANG_W-1:0];
      grade             <= grade_of(aang);
      comparable        <= ((fx != '0) || (fy != '0)) && ((tx != '0) || (ty != '0));
    end
  end

  a_cordic_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cdone |-> (state == S_ANGT_WAIT || state == S_ANGS_WAIT))
    else $error("CORDIC finished outside an angle wait state");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result appeared without a finished compare");

  a_zero_target_gain: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (tmag != '0 || gain_ratio == '0))
    else $error("nonzero gain for a zero target magnitude");

endmodule
